@@ hw/rtl/lscd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lscd_pkg: shared types and constants of the line sensor centroid block
// Widths of the partial sums and of the words handed between the cells.
// -----------------------------------------------------------------------------
package lscd_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_W    = 12;
  localparam int TSUM_W      = SAMPLE_W + 3;   // sum of eight samples
  localparam int WSUM_W      = SAMPLE_W + 6;   // signed weighted sum, |W| <= 16 * max
  localparam int WEIGHT_W    = 5;              // doubled weight, -7 .. +9 while it walks
  localparam int CNT_W       = 4;              // black channel count, 0 .. 8
  localparam int QUOT_W      = 8;              // quotient, top bit marks >= 128
  localparam int DIV_W       = SAMPLE_W + 10;  // 50 * |W| and T << 7 both fit
  localparam int DEV_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_FIRST = -5'sd7;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_STEP  = 5'sd2;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_END   = 5'sd9;

  localparam logic [QUOT_W-1:0] DEV_LIMIT = 8'd100;

  localparam logic [CFG_IDX_W-1:0] REG_BLACK_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_MIN_COUNT = 2'd1;

  localparam logic [SAMPLE_W-1:0] BLACK_THRESHOLD_RST  = 12'd2048;
  localparam logic [CNT_W-1:0]    CORNER_MIN_COUNT_RST = 4'd6;

  // word handed along the accumulation cells
  typedef struct packed {
    logic [CHANNELS-1:0][SAMPLE_W-1:0] samples;   // channel still to add sits at [0]
    logic signed [WEIGHT_W-1:0]        weight;
    logic signed [WSUM_W-1:0]          wsum;
    logic [TSUM_W-1:0]                 tsum;
    logic [CNT_W-1:0]                  black_cnt;
  } acc_word_t;

  // word handed along the divider cells
  typedef struct packed {
    logic [DIV_W-1:0]  rem;
    logic [DIV_W-1:0]  dsh;      // divisor, shifted right by one per cell
    logic [QUOT_W-1:0] quot;
    logic              neg;
    logic              zero;
    logic              corner;
  } div_word_t;

endpackage

`default_nettype wire

@@ hw/rtl/line_sensor_centroid_deviation.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// line_sensor_centroid_deviation: weighted centroid and corner detector
// Eight accumulation cells, a setup stage, eight divider cells and an output
// register, all chained with per-stage valid/ready.
// -----------------------------------------------------------------------------
//
//  channel   dir  width  content
//  s_axis    in   96     one scan, sample_0 .. sample_7
//  m_axis    out  16     deviation and corner flag
//  cfg       in   12     register writes, no read-back
//
//  A scan passes through all 18 stages to the output word; a new scan can
//  enter every cycle, one per cycle sustained while m_axis_tready holds.
//  Each stage holds while its successor is full and stalled, so bubbles close
//  up and a waiting output word does not block input until the chain fills.
//  Reset clears all stage valids and loads the register defaults.
//
module line_sensor_centroid_deviation (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire  [lscd_pkg::CHANNELS*lscd_pkg::SAMPLE_W-1:0]
                                        s_axis_tdata,   // sample_0 [11:0] .. sample_7 [95:84]
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // deviation [7:0], corner_seen [8]
  input  wire                           cfg_we_i,
  input  wire  [lscd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [lscd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lscd_pkg::*;

  logic [SAMPLE_W-1:0] thresh_q;
  logic [CNT_W-1:0]    cmin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= BLACK_THRESHOLD_RST;
      cmin_q   <= CORNER_MIN_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BLACK_THRESHOLD:  thresh_q <= cfg_data_i[SAMPLE_W-1:0];
        REG_CORNER_MIN_COUNT: cmin_q   <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulation chain
  acc_word_t           acc_w [CHANNELS+1];
  logic [CHANNELS:0]   acc_v;
  logic [CHANNELS:0]   acc_r;

  always_comb begin
    acc_w[0].samples   = s_axis_tdata[CHANNELS*SAMPLE_W-1:0];
    acc_w[0].weight    = WEIGHT_FIRST;
    acc_w[0].wsum      = '0;
    acc_w[0].tsum      = '0;
    acc_w[0].black_cnt = '0;
  end

  assign acc_v[0]      = s_axis_tvalid;
  assign s_axis_tready = acc_r[0];

  for (genvar g = 0; g < CHANNELS; g++) begin : g_acc
    lscd_acc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .thresh_i (thresh_q),
      .valid_i  (acc_v[g]),
      .ready_o  (acc_r[g]),
      .word_i   (acc_w[g]),
      .valid_o  (acc_v[g+1]),
      .ready_i  (acc_r[g+1]),
      .word_o   (acc_w[g+1])
    );
  end

  // divider chain
  div_word_t           div_w [QUOT_W+1];
  logic [QUOT_W:0]     div_v;
  logic [QUOT_W:0]     div_r;

  lscd_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .corner_min_i (cmin_q),
    .valid_i      (acc_v[CHANNELS]),
    .ready_o      (acc_r[CHANNELS]),
    .word_i       (acc_w[CHANNELS]),
    .valid_o      (div_v[0]),
    .ready_i      (div_r[0]),
    .word_o       (div_w[0])
  );

  for (genvar g = 0; g < QUOT_W; g++) begin : g_div
    lscd_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_v[g]),
      .ready_o (div_r[g]),
      .word_i  (div_w[g]),
      .valid_o (div_v[g+1]),
      .ready_i (div_r[g+1]),
      .word_o  (div_w[g+1])
    );
  end

  // output register: clamp, apply sign
  logic              out_valid_q;
  logic [DEV_W-1:0]  dev_q, dev_d;
  logic              corner_q;
  logic [QUOT_W-1:0] mag;
  div_word_t         fin;

  always_comb begin
    fin = div_w[QUOT_W];
    mag = (fin.quot > DEV_LIMIT) ? DEV_LIMIT : fin.quot;
    if (fin.zero) begin
      dev_d = '0;
    end else if (fin.neg) begin
      dev_d = DEV_W'(-mag);
    end else begin
      dev_d = DEV_W'(mag);
    end
  end

  assign div_r[QUOT_W] = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_r[QUOT_W]) begin
      out_valid_q <= div_v[QUOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_r[QUOT_W] && div_v[QUOT_W]) begin
      dev_q    <= dev_d;
      corner_q <= fin.corner;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, corner_q, dev_q};

  // an empty output register leaves the whole chain open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // weight has walked across every accumulation cell
  a_weight_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_v[CHANNELS] |-> (acc_w[CHANNELS].weight == WEIGHT_END))
    else $error("accumulation weight out of step");

  a_dev_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[7:0]) >= -8'sd100 &&
                       $signed(m_axis_tdata[7:0]) <= 8'sd100))
    else $error("deviation outside clamp range");

endmodule

`default_nettype wire

@@ hw/rtl/lscd_acc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lscd_acc_cell: one accumulation cell
// Adds the channel at the bottom of the word to the weighted sum, the total
// and the black count, then shifts the samples down and advances the weight.
// -----------------------------------------------------------------------------
module lscd_acc_cell (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire  [lscd_pkg::SAMPLE_W-1:0]  thresh_i,
  input  wire                            valid_i,
  output logic                           ready_o,
  input  wire  lscd_pkg::acc_word_t      word_i,
  output logic                           valid_o,
  input  wire                            ready_i,
  output lscd_pkg::acc_word_t            word_o
);
  import lscd_pkg::*;

  logic                     valid_q;
  acc_word_t                word_q, word_d;
  logic [SAMPLE_W-1:0]      smp;
  logic signed [WSUM_W-1:0] wt_x, smp_x, prod;

  always_comb begin
    smp   = word_i.samples[0];
    wt_x  = WSUM_W'(word_i.weight);
    smp_x = WSUM_W'(signed'({1'b0, smp}));
    prod  = WSUM_W'(wt_x * smp_x);

    word_d           = word_i;
    word_d.samples   = {SAMPLE_W'(0), word_i.samples[CHANNELS-1:1]};
    word_d.weight    = WEIGHT_W'(word_i.weight + WEIGHT_STEP);
    word_d.wsum      = WSUM_W'(word_i.wsum + prod);
    word_d.tsum      = TSUM_W'(word_i.tsum + TSUM_W'(smp));
    word_d.black_cnt = CNT_W'(word_i.black_cnt + CNT_W'(smp > thresh_i));
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

@@ hw/rtl/lscd_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lscd_prep: divider setup stage
// Turns the sums into |50*W| and T << 7, records sign, zero total and the
// corner decision.
// -----------------------------------------------------------------------------
module lscd_prep (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [lscd_pkg::CNT_W-1:0]   corner_min_i,
  input  wire                          valid_i,
  output logic                         ready_o,
  input  wire  lscd_pkg::acc_word_t    word_i,
  output logic                         valid_o,
  input  wire                          ready_i,
  output lscd_pkg::div_word_t          word_o
);
  import lscd_pkg::*;

  logic                     valid_q;
  div_word_t                word_q, word_d;
  logic signed [WSUM_W-1:0] abs_w;
  logic [DIV_W-1:0]         abs_x;

  always_comb begin
    abs_w = word_i.wsum[WSUM_W-1] ? WSUM_W'(-word_i.wsum) : word_i.wsum;
    abs_x = DIV_W'(unsigned'(abs_w));
    // 50 = 32 + 16 + 2
    word_d.rem    = DIV_W'((abs_x << 5) + (abs_x << 4) + (abs_x << 1));
    word_d.dsh    = DIV_W'(word_i.tsum) << (QUOT_W - 1);
    word_d.quot   = '0;
    word_d.neg    = word_i.wsum[WSUM_W-1];
    word_d.zero   = (word_i.tsum == '0);
    word_d.corner = (word_i.black_cnt >= corner_min_i);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

@@ hw/rtl/lscd_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lscd_div_cell: one restoring divider cell
// Resolves one quotient bit: compare, subtract, then halve the divisor.
// -----------------------------------------------------------------------------
module lscd_div_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  output logic                         ready_o,
  input  wire  lscd_pkg::div_word_t    word_i,
  output logic                         valid_o,
  input  wire                          ready_i,
  output lscd_pkg::div_word_t          word_o
);
  import lscd_pkg::*;

  logic      valid_q;
  div_word_t word_q, word_d;
  logic      fits;

  always_comb begin
    fits        = (word_i.rem >= word_i.dsh);
    word_d      = word_i;
    word_d.rem  = fits ? DIV_W'(word_i.rem - word_i.dsh) : word_i.rem;
    word_d.quot = {word_i.quot[QUOT_W-2:0], fits};
    word_d.dsh  = word_i.dsh >> 1;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

@@ tb/line_sensor_centroid_deviation_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// line_sensor_centroid_deviation_tb: self-checking bench for the centroid block
// Scans go in on the slave stream and results come out on the master stream.
// Each accepted scan is predicted here and checked against the returned word.
// A directed set covers the corner cases, then random scans follow under a
// series of threshold and count settings. Each phase may let either stream side idle at random.
// -----------------------------------------------------------------------------
module line_sensor_centroid_deviation_tb;
  import lscd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] scan_t;

  typedef struct packed {
    logic signed [DEV_W-1:0] deviation;
    logic                    corner_seen;
  } centroid_t;

  logic clk_i;
  logic rst_n = 1'b0;

  logic        s_valid = 1'b0;
  logic        s_ready;
  scan_t       s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies used for prediction
  logic [SAMPLE_W-1:0] thr_model = BLACK_THRESHOLD_RST;
  logic [CNT_W-1:0]    min_model = CORNER_MIN_COUNT_RST;

  scan_t     scan_q[$];
  centroid_t centroid_due_q[$];

  bit snd_idle_en = 1'b1;
  bit rcv_idle_en = 1'b1;
  int in_gap = 0;
  int out_wait = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int errors = 0;
  int cycles = 0;

  line_sensor_centroid_deviation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),    // sample_0 [11:0] .. sample_7 [95:84]
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),    // deviation [7:0], corner_seen [8]
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic centroid_t centroid_of(input scan_t s);
    centroid_t r;
    int weighted;
    int total;
    int black;
    int q;
    weighted = 0;
    total = 0;
    black = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      weighted += (2 * i - (CHANNELS - 1)) * int'(s[i]);
      total += int'(s[i]);
      if (s[i] > thr_model) black++;
    end
    if (total == 0) begin
      q = 0;
    end else begin
      q = (weighted * 50) / total;
      if (q > int'(DEV_LIMIT)) q = int'(DEV_LIMIT);
      if (q < -int'(DEV_LIMIT)) q = -int'(DEV_LIMIT);
    end
    r.deviation = q[DEV_W-1:0];
    r.corner_seen = (black >= int'(min_model));
    return r;
  endfunction

  function automatic int draw_gap(input bit en);
    return en ? int'($urandom_range(0, 3)) : 0;
  endfunction

  function automatic scan_t mask_scan(input logic [CHANNELS-1:0] mask,
                                      input logic [SAMPLE_W-1:0] val);
    scan_t s;
    for (int i = 0; i < CHANNELS; i++) s[i] = mask[i] ? val : '0;
    return s;
  endfunction

  function automatic scan_t pair_scan(input int a, input logic [SAMPLE_W-1:0] va,
                                      input int b, input logic [SAMPLE_W-1:0] vb);
    scan_t s;
    s = '0;
    s[a] = va;
    s[b] = vb;
    return s;
  endfunction

  function automatic scan_t random_scan();
    scan_t s;
    bit sparse;
    int v;
    sparse = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < CHANNELS; i++) begin
      if (sparse) begin
        // few small samples: deviation lands inside the range, truncation shows
        s[i] = ($urandom_range(0, 4) < 3) ? '0 : SAMPLE_W'($urandom_range(0, 15));
      end else begin
        case ($urandom_range(0, 7))
          0: s[i] = '0;
          1: s[i] = SAMPLE_MAX;
          2, 3: begin
            v = int'(thr_model) + int'($urandom_range(0, 2)) - 1;
            if (v < 0) v = 0;
            if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
            s[i] = v[SAMPLE_W-1:0];
          end
          default: s[i] = SAMPLE_W'($urandom_range(0, 4095));
        endcase
      end
    end
    return s;
  endfunction

  // scan driver: hold the word until taken, then idle or advance
  always @(negedge clk_i) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else if (!s_valid || in_taken) begin
      if (in_gap != 0) begin
        s_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (scan_q.size() != 0) begin
        s_valid <= 1'b1;
        s_data <= scan_q.pop_front();
        in_gap <= draw_gap(snd_idle_en);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // result receiver: after each word taken, hold ready low for a random gap from draw_gap
  always @(negedge clk_i) begin : rx_ready
    int w;
    if (out_taken) begin
      w = draw_gap(rcv_idle_en);
      if (w > 0) begin
        m_ready <= 1'b0;
        out_wait <= w - 1;
      end else begin
        m_ready <= 1'b1;
      end
    end else if (out_wait > 0) begin
      m_ready <= 1'b0;
      out_wait <= out_wait - 1;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : monitor
    centroid_t got;
    centroid_t want;
    in_taken <= s_valid && s_ready;
    out_taken <= m_valid && m_ready;
    if (s_valid && s_ready) centroid_due_q.push_back(centroid_of(s_data));
    if (m_valid && m_ready) begin
      got.deviation = m_data[7:0];
      got.corner_seen = m_data[8];
      if (centroid_due_q.size() == 0) begin
        $display("%0t: unexpected word, got deviation %0d corner %0b",
                 $time, got.deviation, got.corner_seen);
        errors++;
      end else begin
        want = centroid_due_q.pop_front();
        if (got.deviation !== want.deviation) begin
          $display("%0t: deviation expected %0d got %0d",
                   $time, want.deviation, got.deviation);
          errors++;
        end
        if (got.corner_seen !== want.corner_seen) begin
          $display("%0t: corner_seen expected %0b got %0b",
                   $time, want.corner_seen, got.corner_seen);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("line_sensor_centroid_deviation_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLACK_THRESHOLD:  thr_model = data[SAMPLE_W-1:0];
      REG_CORNER_MIN_COUNT: min_model = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every scan is sent and every result is back, then let the chain empty
  task automatic settle();
    while (scan_q.size() != 0 || s_valid || centroid_due_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] thr,
                           input logic [CFG_DATA_W-1:0] min_cnt,
                           input bit spare, input bit snd_idle,
                           input bit rcv_idle, input int n);
    settle();
    write_reg(REG_BLACK_THRESHOLD, thr);
    write_reg(REG_CORNER_MIN_COUNT, min_cnt);
    // writes to unused indexes must leave both registers alone
    if (spare) begin
      write_reg(REG_SPARE_2, 12'h000);
      write_reg(REG_SPARE_3, 12'h001);
    end
    snd_idle_en = snd_idle;
    rcv_idle_en = rcv_idle;
    repeat (n) scan_q.push_back(random_scan());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // directed scans under the reset settings
    scan_q.push_back(mask_scan(8'hFF, 12'h000));
    scan_q.push_back(mask_scan(8'hFF, SAMPLE_MAX));
    scan_q.push_back(mask_scan(8'hFF, 12'hAAA));
    scan_q.push_back(mask_scan(8'hFF, 12'h555));
    scan_q.push_back(mask_scan(8'hFF, 12'd2048));
    scan_q.push_back(mask_scan(8'hFF, 12'd2049));
    for (int i = 0; i < CHANNELS; i++)
      scan_q.push_back(mask_scan(CHANNELS'(1) << i, SAMPLE_MAX));
    scan_q.push_back(pair_scan(3, 12'd2, 4, 12'd1));
    scan_q.push_back(pair_scan(3, 12'd1, 4, 12'd2));
    scan_q.push_back(pair_scan(0, SAMPLE_MAX, 5, SAMPLE_MAX));
    scan_q.push_back(pair_scan(2, SAMPLE_MAX, 7, SAMPLE_MAX));
    scan_q.push_back(pair_scan(0, 12'd1, 0, 12'd1));
    scan_q.push_back(mask_scan(8'h3F, SAMPLE_MAX));
    scan_q.push_back(mask_scan(8'h1F, SAMPLE_MAX));
    repeat (100) scan_q.push_back(random_scan());

    run_phase(12'd0,    12'd0,   1'b0, 1'b0, 1'b1, 110);
    run_phase(12'hFFF,  12'd8,   1'b0, 1'b1, 1'b1, 110);
    run_phase(12'd0,    12'h008, 1'b0, 1'b1, 1'b0, 110);
    run_phase(12'($urandom_range(1, 4094)), 12'hFF9, 1'b1, 1'b0, 1'b0, 110);
    run_phase(12'($urandom_range(1, 4094)), 12'h00F, 1'b0, 1'b1, 1'b1, 110);
    run_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(1, 7)),
              1'b0, 1'b1, 1'b1, 110);
    run_phase(12'h800,  12'h006, 1'b0, 1'b1, 1'b1, 110);
    settle();

    if (errors == 0 && centroid_due_q.size() == 0) begin
      $display("line_sensor_centroid_deviation_tb: done, clean");
    end else begin
      $display("line_sensor_centroid_deviation_tb: done, errors");
    end
    $finish;
  end

endmodule
